// ===== hw/rtl/ras_pkg.sv =====
// ----------------------------------------------------------------------------
// ras_pkg
// shared types and constants for the room assignment scheduler
// ----------------------------------------------------------------------------
package ras_pkg;

  localparam int TIME_W  = 48;
  localparam int COUNT_W = 24;
  localparam int IN_W    = 32;
  localparam int CFG_W   = 5;
  localparam int IDX_W   = 4;

  localparam logic [TIME_W-1:0]  TIME_MAX    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [CFG_W-1:0]   ROOMS_RESET = 5'd16;

  typedef struct packed {
    logic [IN_W-1:0] start_time;
    logic [IN_W-1:0] end_time;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   assigned_room;
    logic [TIME_W-1:0]  begin_time;
    logic [TIME_W-1:0]  finish_time;
    logic [IDX_W-1:0]   most_booked_room;
    logic [COUNT_W-1:0] most_booked_count;
    logic               rejected;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_t;

endpackage

// ===== hw/rtl/room_assign_scheduler.sv =====
// ----------------------------------------------------------------------------
// room_assign_scheduler
// assigns each meeting to a room and tracks the most-booked room
// ----------------------------------------------------------------------------
// usage:
//   a meeting (start_time, end_time) transfers in when start is high and busy
//   is low; meetings must come in nondecreasing start order
//   one result per meeting appears on result, marked by done, which is high for
//   exactly one cycle; the receiver cannot stall, so a result must be taken then
//   an out-of-order or empty meeting gives done on the next cycle with
//   rejected set and changes nothing
//   an accepted meeting reads every active room's busy-until from the room
//   memory, one per cycle, then reads the chosen room's use count and writes
//   back; done is registered after the write-back in ST_UPDATE, which follows
//   the scan (ST_SCAN) and ST_LAST; busy stays high through ST_SCAN, ST_LAST and
//   ST_UPDATE, so a new meeting is taken only once the last one is written
//   back; the single memory read port and the per-room scan set this limit
//   cfg_we/cfg_wdata write rooms_in_use; write it only while idle
//   reset: rooms_in_use returns to 16, all rooms read as free with zero
//   uses through per-room valid bits, so there is no clearing pass
// ----------------------------------------------------------------------------
module room_assign_scheduler #(
  parameter int ROOMS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  ras_pkg::item_t           item,
  output logic                     done,
  output ras_pkg::result_t         result,
  input  logic                     cfg_we,
  input  logic [ras_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CW = $clog2(ROOMS + 1);

  // room memories: busy-until time and use count per room
  logic [ras_pkg::TIME_W-1:0]  busy_mem [ROOMS];
  logic [ras_pkg::COUNT_W-1:0] uses_mem [ROOMS];
  logic [ROOMS-1:0]            vld;

  logic [ras_pkg::TIME_W-1:0]  busy_rd;
  logic [ras_pkg::COUNT_W-1:0] uses_rd;
  logic                        vld_rd;
  logic [RW-1:0]               rd_addr;
  logic                        mem_we;

  ras_pkg::state_t state, state_next;

  logic [ras_pkg::CFG_W-1:0]   rooms_in_use;
  logic [CW-1:0]               active;
  logic [RW-1:0]               last_idx;

  logic [RW-1:0]               scan_idx;
  logic [RW-1:0]               data_idx;
  logic                        rd_pending;

  logic                        found, found_next;
  logic [RW-1:0]               free_room, free_room_next;
  logic [RW-1:0]               earl_idx, earl_idx_next;
  logic [ras_pkg::TIME_W-1:0]  earl_val, earl_val_next;

  logic [ras_pkg::IN_W-1:0]    start_q;
  logic [ras_pkg::IN_W-1:0]    dur_q;
  logic [ras_pkg::IN_W-1:0]    prev_start;
  logic [RW-1:0]               best_room;
  logic [ras_pkg::COUNT_W-1:0] best_count;

  logic                        accept;
  logic                        reject;
  logic [ras_pkg::TIME_W-1:0]  data_busy;
  logic                        free_hit;
  logic [RW-1:0]               chosen_next;
  logic [RW-1:0]               room;
  logic [ras_pkg::TIME_W-1:0]  begin_t;
  logic [ras_pkg::TIME_W:0]    finish_sum;
  logic [ras_pkg::TIME_W-1:0]  finish_t;
  logic [ras_pkg::COUNT_W-1:0] uses_cur;
  logic [ras_pkg::COUNT_W-1:0] uses_inc;
  logic                        new_best;
  logic [RW-1:0]               best_room_next;
  logic [ras_pkg::COUNT_W-1:0] best_count_next;

  // active room count, zero acts as one and anything above ROOMS as ROOMS
  always_comb begin
    if (rooms_in_use == '0) begin
      active = CW'(1);
    end else if (32'(rooms_in_use) > ROOMS) begin
      active = CW'(ROOMS);
    end else begin
      active = CW'(rooms_in_use);
    end
  end
  assign last_idx = RW'(active - CW'(1));

  // input checks on the transfer
  assign accept = start && !busy;
  assign reject = (item.start_time < prev_start) || (item.end_time <= item.start_time);

  // scan compare on the data read the cycle before
  assign data_busy = vld_rd ? busy_rd : '0;
  assign free_hit  = data_busy <= ras_pkg::TIME_W'(start_q);

  always_comb begin
    found_next     = found;
    free_room_next = free_room;
    earl_idx_next  = earl_idx;
    earl_val_next  = earl_val;
    if (rd_pending) begin
      if (data_idx == '0) begin
        found_next     = free_hit;
        free_room_next = '0;
        earl_idx_next  = '0;
        earl_val_next  = data_busy;
      end else begin
        if (!found && free_hit) begin
          found_next     = 1'b1;
          free_room_next = data_idx;
        end
        if (data_busy < earl_val) begin
          earl_idx_next = data_idx;
          earl_val_next = data_busy;
        end
      end
    end
  end

  // lowest free room wins, else the earliest busy-until
  assign chosen_next = found_next ? free_room_next : earl_idx_next;
  assign room        = found ? free_room : earl_idx;

  // update arithmetic: a free room starts on time, otherwise wait for it
  assign begin_t    = found ? ras_pkg::TIME_W'(start_q) : earl_val;
  assign finish_sum = {1'b0, begin_t} + (ras_pkg::TIME_W + 1)'(dur_q);
  assign finish_t   = finish_sum[ras_pkg::TIME_W] ? ras_pkg::TIME_MAX
                                                  : finish_sum[ras_pkg::TIME_W-1:0];
  assign uses_cur   = vld_rd ? uses_rd : '0;
  assign uses_inc   = (uses_cur == ras_pkg::COUNT_MAX) ? uses_cur
                                                       : uses_cur + ras_pkg::COUNT_W'(1);
  assign new_best   = (uses_inc > best_count) ||
                      ((uses_inc == best_count) && (room < best_room));
  assign best_room_next  = new_best ? room : best_room;
  assign best_count_next = new_best ? uses_inc : best_count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ras_pkg::ST_IDLE: begin
        if (accept && !reject) begin
          state_next = ras_pkg::ST_SCAN;
        end
      end
      ras_pkg::ST_SCAN: begin
        if (scan_idx == last_idx) begin
          state_next = ras_pkg::ST_LAST;
        end
      end
      ras_pkg::ST_LAST:   state_next = ras_pkg::ST_UPDATE;
      ras_pkg::ST_UPDATE: state_next = ras_pkg::ST_IDLE;
      default:            state_next = ras_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy    = 1'b1;
    rd_addr = scan_idx;
    mem_we  = 1'b0;
    case (state)
      ras_pkg::ST_IDLE:   busy = 1'b0;
      ras_pkg::ST_SCAN:   rd_addr = scan_idx;
      ras_pkg::ST_LAST:   rd_addr = chosen_next;
      ras_pkg::ST_UPDATE: mem_we = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  // room memories, one read port with registered data, one write port
  always_ff @(posedge clk) begin
    busy_rd <= busy_mem[rd_addr];
    uses_rd <= uses_mem[rd_addr];
    if (mem_we) begin
      busy_mem[room] <= finish_t;
      uses_mem[room] <= uses_inc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ras_pkg::ST_IDLE;
      vld          <= '0;
      vld_rd       <= 1'b0;
      rd_pending   <= 1'b0;
      rooms_in_use <= ras_pkg::ROOMS_RESET;
      prev_start   <= '0;
      best_room    <= '0;
      best_count   <= '0;
      done         <= 1'b0;
    end else begin
      state      <= state_next;
      vld_rd     <= vld[rd_addr];
      rd_pending <= (state == ras_pkg::ST_SCAN);
      // strobe for a refused transfer or a finished write-back
      done       <= (accept && reject) || mem_we;
      if (cfg_we) begin
        rooms_in_use <= cfg_wdata;
      end
      if (accept && !reject) begin
        prev_start <= item.start_time;
      end
      if (mem_we) begin
        vld[room]  <= 1'b1;
        best_room  <= best_room_next;
        best_count <= best_count_next;
      end
    end
  end

  // scan bookkeeping and result register
  always_ff @(posedge clk) begin
    data_idx  <= scan_idx;
    found     <= found_next;
    free_room <= free_room_next;
    earl_idx  <= earl_idx_next;
    earl_val  <= earl_val_next;
    if (state == ras_pkg::ST_SCAN && scan_idx != last_idx) begin
      scan_idx <= scan_idx + RW'(1);
    end
    if (accept) begin
      scan_idx <= '0;
      start_q  <= item.start_time;
      dur_q    <= item.end_time - item.start_time;
      result.assigned_room     <= '0;
      result.begin_time        <= '0;
      result.finish_time       <= '0;
      result.most_booked_room  <= ras_pkg::IDX_W'(best_room);
      result.most_booked_count <= best_count;
      result.rejected          <= 1'b1;
    end
    if (mem_we) begin
      result.assigned_room     <= ras_pkg::IDX_W'(room);
      result.begin_time        <= begin_t;
      result.finish_time       <= finish_t;
      result.most_booked_room  <= ras_pkg::IDX_W'(best_room_next);
      result.most_booked_count <= best_count_next;
      result.rejected          <= 1'b0;
    end
  end

  // checks
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ras_pkg::ST_UPDATE) || $past(start && !busy))
    else $error("result strobe without an update or a rejected transfer");

  a_good_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && !reject) |=> (state == ras_pkg::ST_SCAN))
    else $error("accepted meeting did not start a room scan");

  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    (done && !result.rejected) |-> (result.finish_time >= result.begin_time))
    else $error("finish time before begin time");

  a_reject_clear: assert property (@(posedge clk) disable iff (rst)
    (done && result.rejected) |-> (result.begin_time == '0) && (result.finish_time == '0))
    else $error("rejected result carries times");

endmodule
